// File: src/osq_pkg.sv
// Shared types, codes and helpers for the owned segment queue store.
`default_nettype none

package osq_pkg;

	localparam logic [2:0] KIND_ALLOC = 3'd0;
	localparam logic [2:0] KIND_FREE  = 3'd1;
	localparam logic [2:0] KIND_PUT   = 3'd2;
	localparam logic [2:0] KIND_GET   = 3'd3;
	localparam logic [2:0] KIND_INFO  = 3'd4;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_BAD_SEG  = 3'd1;
	localparam logic [2:0] ST_DENIED   = 3'd2;
	localparam logic [2:0] ST_END      = 3'd3;
	localparam logic [2:0] ST_EMPTY    = 3'd4;
	localparam logic [2:0] ST_NOT_AGED = 3'd5;
	localparam logic [2:0] ST_INVALID  = 3'd6;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  segment;
		logic [47:0] owner_id;
		logic [63:0] name_tag;
		logic [63:0] payload;
		logic [3:0]  byte_count;
		logic [31:0] now_seconds;
		logic [30:0] min_age;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [63:0] out_payload;
		logic [3:0]  out_byte_count;
		logic [47:0] out_owner;
		logic [63:0] out_name;
		logic [8:0]  fill_count;
	} rsp_t;

	typedef struct packed {
		logic [31:0] stamp;
		logic [3:0]  len;
		logic [63:0] data;
	} ent_t;

	typedef struct packed {
		logic load;
		logic decide;
		logic finish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic needs_fetch;
	} ctrl_sts_t;

	// Keep byte i only when i is below the count.
	function automatic logic [63:0] keep_bytes(input logic [63:0] v, input logic [3:0] n);
		logic [63:0] m;
		m = '0;
		for (int i = 0; i < 8; i++) begin
			if (4'(i) < n) m[8*i +: 8] = 8'hFF;
		end
		return v & m;
	endfunction

endpackage

`default_nettype wire

// File: src/osq_ctrl.sv
// Request sequencer: lookup, optional entry fetch, result strobe.
`default_nettype none

module osq_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire osq_pkg::ctrl_sts_t sts,
	output osq_pkg::ctrl_cmd_t      cmd,
	output logic                    busy,
	output logic                    done
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOOK,
		S_FETCH
	} state_t;

	state_t state_q;
	logic   done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					done_q <= 1'b0;
					if (start) state_q <= S_LOOK;
				end
				S_LOOK: begin
					if (sts.needs_fetch) begin
						state_q <= S_FETCH;
						done_q  <= 1'b0;
					end else begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end
				end
				S_FETCH: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= S_IDLE;
					done_q  <= 1'b0;
				end
			endcase
		end
	end

	assign cmd.load   = (state_q == S_IDLE) && start;
	assign cmd.decide = (state_q == S_LOOK);
	assign cmd.finish = (state_q == S_FETCH);
	assign busy       = (state_q != S_IDLE);
	assign done       = done_q;

endmodule

`default_nettype wire

// File: src/osq_dp.sv
// Segment table, entry memory and request evaluation.
`default_nettype none

module osq_dp #(
	parameter int SEGMENTS  = 16,
	parameter int CAPACITY  = 256,
	parameter int MAX_BYTES = 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire osq_pkg::req_t      req,
	input  wire osq_pkg::ctrl_cmd_t cmd,
	output osq_pkg::ctrl_sts_t      sts,
	output osq_pkg::rsp_t           rsp
);

	localparam int SEG_W  = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
	localparam int PTR_W  = $clog2(CAPACITY + 1);
	localparam int SLOTS  = SEGMENTS * CAPACITY;
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int EXT_W  = (PTR_W > 9) ? PTR_W : 9;
	localparam logic [PTR_W-1:0] CAP_P = PTR_W'(CAPACITY);
	localparam logic [3:0]       MAXB  = 4'(MAX_BYTES);

	osq_pkg::req_t req_q;

	// Segment table: owner, name, read and write pointers per segment.
	logic [47:0]      owner_mem [SEGMENTS];
	logic [63:0]      name_mem  [SEGMENTS];
	logic [PTR_W-1:0] rptr_mem  [SEGMENTS];
	logic [PTR_W-1:0] wptr_mem  [SEGMENTS];
	logic [SEGMENTS-1:0] seg_vld_q;

	logic [47:0]      owner_rd_q;
	logic [63:0]      name_rd_q;
	logic [PTR_W-1:0] rptr_rd_q;
	logic [PTR_W-1:0] wptr_rd_q;
	logic             vld_rd_q;

	osq_pkg::ent_t ent_mem [SLOTS];
	osq_pkg::ent_t ent_rd_q;
	osq_pkg::ent_t ent_wr;

	osq_pkg::rsp_t rsp_q;
	osq_pkg::rsp_t dec_rsp;
	osq_pkg::rsp_t fin_rsp;

	logic [SEG_W-1:0]  in_idx;
	logic [SEG_W-1:0]  idx_q;
	logic              in_range;
	logic              match;
	logic [47:0]       cur_owner;
	logic [63:0]       cur_name;
	logic [PTR_W-1:0]  cur_rptr;
	logic [PTR_W-1:0]  cur_wptr;
	logic [47:0]       nx_owner;
	logic [63:0]       nx_name;
	logic [PTR_W-1:0]  nx_rptr;
	logic [PTR_W-1:0]  nx_wptr;
	logic [PTR_W-1:0]  wr_rptr;
	logic [PTR_W-1:0]  ptr_sel;
	logic [SLOT_W-1:0] slot;
	logic [EXT_W-1:0]  fill_ext;
	logic              dec_we;
	logic              put_we;
	logic              fetch;
	logic              fin_we;
	logic              seg_we;
	logic [32:0]       age_sum;
	logic              not_aged;

	assign in_idx   = req.segment[SEG_W-1:0];
	assign idx_q    = req_q.segment[SEG_W-1:0];
	assign in_range = ({1'b0, req_q.segment} < 9'(SEGMENTS));

	// A segment never written reads as all zero.
	assign cur_owner = vld_rd_q ? owner_rd_q : '0;
	assign cur_name  = vld_rd_q ? name_rd_q  : '0;
	assign cur_rptr  = vld_rd_q ? rptr_rd_q  : '0;
	assign cur_wptr  = vld_rd_q ? wptr_rd_q  : '0;

	assign match    = (cur_owner == req_q.owner_id) && (cur_name == req_q.name_tag);
	assign fill_ext = EXT_W'(cur_wptr) - EXT_W'(cur_rptr);

	always_comb begin
		dec_rsp        = '0;
		dec_rsp.status = osq_pkg::ST_OK;
		nx_owner       = cur_owner;
		nx_name        = cur_name;
		nx_rptr        = cur_rptr;
		nx_wptr        = cur_wptr;
		ptr_sel        = cur_rptr;
		dec_we         = 1'b0;
		put_we         = 1'b0;
		fetch          = 1'b0;
		if (req_q.kind > osq_pkg::KIND_INFO) begin
			dec_rsp.status = osq_pkg::ST_DENIED;
		end else if (!in_range) begin
			dec_rsp.status = osq_pkg::ST_BAD_SEG;
		end else begin
			case (req_q.kind)
				osq_pkg::KIND_ALLOC: begin
					if (cur_owner == '0) begin
						nx_owner = req_q.owner_id;
						nx_name  = req_q.name_tag;
						dec_we   = 1'b1;
					end else begin
						dec_rsp.status = osq_pkg::ST_DENIED;
					end
				end
				osq_pkg::KIND_FREE: begin
					if (cur_rptr >= cur_wptr) begin
						nx_owner = '0;
						nx_rptr  = '0;
						nx_wptr  = '0;
						dec_we   = 1'b1;
					end else begin
						dec_rsp.status = osq_pkg::ST_DENIED;
					end
				end
				osq_pkg::KIND_INFO: begin
					dec_rsp.out_owner  = cur_owner;
					dec_rsp.out_name   = cur_name;
					dec_rsp.fill_count = fill_ext[8:0];
				end
				osq_pkg::KIND_PUT: begin
					if (!match) begin
						dec_rsp.status = osq_pkg::ST_DENIED;
					end else if (cur_wptr < CAP_P) begin
						put_we  = 1'b1;
						ptr_sel = cur_wptr;
						nx_wptr = cur_wptr + PTR_W'(1);
						dec_we  = 1'b1;
					end else begin
						dec_rsp.status = osq_pkg::ST_END;
					end
				end
				osq_pkg::KIND_GET: begin
					if (!match) begin
						dec_rsp.status = osq_pkg::ST_DENIED;
					end else if (cur_rptr < cur_wptr) begin
						fetch = 1'b1;
					end else if (cur_rptr >= CAP_P) begin
						dec_rsp.status = osq_pkg::ST_END;
					end else begin
						dec_rsp.status = osq_pkg::ST_EMPTY;
					end
				end
				default: dec_rsp.status = osq_pkg::ST_DENIED;
			endcase
		end
	end

	// Entry is old enough when min_age is zero or stamp + min_age <= now.
	assign age_sum  = {1'b0, ent_rd_q.stamp} + 33'(req_q.min_age);
	assign not_aged = (req_q.min_age != '0) && (age_sum > {1'b0, req_q.now_seconds});

	always_comb begin
		fin_rsp = '0;
		fin_we  = 1'b0;
		if (not_aged) begin
			fin_rsp.status = osq_pkg::ST_NOT_AGED;
		end else begin
			fin_we = 1'b1;
			if (ent_rd_q.len == '0 || ent_rd_q.len > MAXB) begin
				fin_rsp.status = osq_pkg::ST_INVALID;
			end else begin
				fin_rsp.status         = osq_pkg::ST_OK;
				fin_rsp.out_payload    = ent_rd_q.data;
				fin_rsp.out_byte_count = ent_rd_q.len;
			end
		end
	end

	assign seg_we  = (cmd.decide && dec_we) || (cmd.finish && fin_we);
	assign wr_rptr = cmd.finish ? (cur_rptr + PTR_W'(1)) : nx_rptr;
	assign slot    = SLOT_W'(SLOT_W'(idx_q) * SLOT_W'(CAPACITY) + SLOT_W'(ptr_sel));

	assign ent_wr.stamp = req_q.now_seconds;
	assign ent_wr.len   = req_q.byte_count;
	assign ent_wr.data  = osq_pkg::keep_bytes(req_q.payload, req_q.byte_count);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q      <= req;
			owner_rd_q <= owner_mem[in_idx];
			name_rd_q  <= name_mem[in_idx];
			rptr_rd_q  <= rptr_mem[in_idx];
			wptr_rd_q  <= wptr_mem[in_idx];
			vld_rd_q   <= seg_vld_q[in_idx];
		end
		if (seg_we) begin
			owner_mem[idx_q] <= nx_owner;
			name_mem[idx_q]  <= nx_name;
			rptr_mem[idx_q]  <= wr_rptr;
			wptr_mem[idx_q]  <= nx_wptr;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.decide && put_we) ent_mem[slot] <= ent_wr;
		if (cmd.decide && fetch) ent_rd_q <= ent_mem[slot];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_vld_q <= '0;
		end else if (seg_we) begin
			seg_vld_q[idx_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) rsp_q <= fin_rsp;
		else if (cmd.decide && !fetch) rsp_q <= dec_rsp;
	end

	assign sts.needs_fetch = fetch;
	assign rsp             = rsp_q;

endmodule

`default_nettype wire

// File: src/owned_segment_queue_store.sv
// Top level of the owned segment queue store.
//
// Requests: drive req and raise start; the beat is taken at a rising edge
// with start high and busy low. busy stays high until the result is out.
// Results: done is high for exactly one cycle with the result on rsp; the
// receiver takes every result and cannot stall it.
// Timing: done rises once the registered segment table read is evaluated, or
// for a get that reaches a stored entry only after the registered entry memory
// read as well; the result is taken at the edge that ends the done cycle. A new
// request can be taken at that same edge, but not while busy is high.
// Reset: all segments read as free with zero pointers and name right after
// reset, through per-segment valid bits; there is no clearing pass. Entry
// memory holds no reset value and is only read below a segment's write
// pointer.
`default_nettype none

module owned_segment_queue_store #(
	parameter int SEGMENTS  = 16,
	parameter int CAPACITY  = 256,
	parameter int MAX_BYTES = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire osq_pkg::req_t req,
	output logic               done,
	output osq_pkg::rsp_t      rsp
);

	osq_pkg::ctrl_cmd_t cmd;
	osq_pkg::ctrl_sts_t sts;

	osq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	osq_dp #(
		.SEGMENTS  (SEGMENTS),
		.CAPACITY  (CAPACITY),
		.MAX_BYTES (MAX_BYTES)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp)
	);

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while request still busy");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted beat did not raise busy");

	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("request finished without a result");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

endmodule

`default_nettype wire

// File: tb/osq_checker.sv
// Watches the request and result beats of the segment queue store, predicts each result, compares.
`timescale 1ns / 1ps

module osq_checker #(
	parameter int SEGMENTS  = 16,
	parameter int CAPACITY  = 256,
	parameter int MAX_BYTES = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic          busy,
	input  wire osq_pkg::req_t req,
	input  wire logic          done,
	input  wire osq_pkg::rsp_t rsp,
	output int                 errors,
	output int                 outstanding
);
	import osq_pkg::*;

	logic [47:0] owner_of [SEGMENTS];
	logic [63:0] tag_of   [SEGMENTS];
	int          rd_ptr   [SEGMENTS];
	int          wr_ptr   [SEGMENTS];

	logic [63:0] slot_data  [SEGMENTS*CAPACITY];
	logic [3:0]  slot_len   [SEGMENTS*CAPACITY];
	logic [31:0] slot_stamp [SEGMENTS*CAPACITY];

	rsp_t awaited_rsp [$];

	// Apply one request to the segment table and return the result it yields.
	function automatic rsp_t predict_response(input req_t r);
		rsp_t   o;
		int     s;
		int     slot;
		longint age_limit;
		o = '0;
		o.status = ST_OK;
		s = int'(r.segment);
		if (r.kind > KIND_INFO) begin
			o.status = ST_DENIED;
		end else if (s >= SEGMENTS) begin
			o.status = ST_BAD_SEG;
		end else begin
			case (r.kind)
				KIND_ALLOC: begin
					if (owner_of[s] == '0) begin
						owner_of[s] = r.owner_id;
						tag_of[s]   = r.name_tag;
					end else begin
						o.status = ST_DENIED;
					end
				end
				KIND_FREE: begin
					// no owner check; the name tag survives
					if (rd_ptr[s] >= wr_ptr[s]) begin
						owner_of[s] = '0;
						rd_ptr[s]   = 0;
						wr_ptr[s]   = 0;
					end else begin
						o.status = ST_DENIED;
					end
				end
				KIND_INFO: begin
					o.out_owner  = owner_of[s];
					o.out_name   = tag_of[s];
					o.fill_count = 9'(wr_ptr[s] - rd_ptr[s]);
				end
				default: begin
					if (owner_of[s] != r.owner_id || tag_of[s] != r.name_tag) begin
						o.status = ST_DENIED;
					end else if (r.kind == KIND_PUT) begin
						if (wr_ptr[s] < CAPACITY) begin
							slot = s * CAPACITY + wr_ptr[s];
							slot_data[slot] = (r.byte_count >= 4'd8) ? r.payload :
								r.payload & ~({64{1'b1}} << (8 * r.byte_count));
							slot_len[slot]   = r.byte_count;
							slot_stamp[slot] = r.now_seconds;
							wr_ptr[s]++;
						end else begin
							o.status = ST_END;
						end
					end else if (rd_ptr[s] < wr_ptr[s]) begin
						slot = s * CAPACITY + rd_ptr[s];
						age_limit = $signed({32'd0, r.now_seconds}) - $signed({33'd0, r.min_age});
						if (r.min_age != '0 && $signed({32'd0, slot_stamp[slot]}) > age_limit) begin
							o.status = ST_NOT_AGED;
						end else begin
							rd_ptr[s]++;
							if (slot_len[slot] == '0 || int'(slot_len[slot]) > MAX_BYTES) begin
								o.status = ST_INVALID;
							end else begin
								o.out_payload    = slot_data[slot];
								o.out_byte_count = slot_len[slot];
							end
						end
					end else if (rd_ptr[s] >= CAPACITY) begin
						o.status = ST_END;
					end else begin
						o.status = ST_EMPTY;
					end
				end
			endcase
		end
		return o;
	endfunction

	function automatic int field_mismatch(input string field, input logic [63:0] want,
			input logic [63:0] got);
		if (got === want) return 0;
		$error("%s: expected %0h, got %0h", field, want, got);
		return 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		int   bad;
		rsp_t want;
		if (!arst_n) begin
			for (int i = 0; i < SEGMENTS; i++) begin
				owner_of[i] = '0;
				tag_of[i]   = '0;
				rd_ptr[i]   = 0;
				wr_ptr[i]   = 0;
			end
			awaited_rsp.delete();
			errors      <= 0;
			outstanding <= 0;
		end else begin
			bad = 0;
			// retire the result first: a new request may be taken on the same edge
			if (done) begin
				if (awaited_rsp.size() == 0) begin
					$error("result beat with no request waiting, status %0d", rsp.status);
					bad++;
				end else begin
					want = awaited_rsp.pop_front();
					bad += field_mismatch("status", 64'(want.status), 64'(rsp.status));
					bad += field_mismatch("out_payload", want.out_payload, rsp.out_payload);
					bad += field_mismatch("out_byte_count", 64'(want.out_byte_count),
						64'(rsp.out_byte_count));
					bad += field_mismatch("out_owner", 64'(want.out_owner),
						64'(rsp.out_owner));
					bad += field_mismatch("out_name", want.out_name, rsp.out_name);
					bad += field_mismatch("fill_count", 64'(want.fill_count),
						64'(rsp.fill_count));
				end
			end
			if (start && !busy) awaited_rsp.push_back(predict_response(req));
			errors      <= errors + bad;
			outstanding <= awaited_rsp.size();
		end
	end

endmodule

// File: tb/tb_top.sv
// Stimulus and verdict for the owned segment queue store, with the result checker beside it.
`timescale 1ns / 1ps

module tb_top;
	import osq_pkg::*;

	localparam int SEGMENTS  = 16;
	localparam int CAPACITY  = 256;
	localparam int MAX_BYTES = 8;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	req_t req;
	logic done;
	rsp_t rsp;

	int          fails;
	int          awaiting;
	int          sent;
	int          idle_pct;
	int unsigned wall;

	owned_segment_queue_store #(
		.SEGMENTS(SEGMENTS), .CAPACITY(CAPACITY), .MAX_BYTES(MAX_BYTES)
	) u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .rsp(rsp)
	);

	osq_checker #(
		.SEGMENTS(SEGMENTS), .CAPACITY(CAPACITY), .MAX_BYTES(MAX_BYTES)
	) u_check (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .rsp(rsp), .errors(fails), .outstanding(awaiting)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic logic [47:0] rand48();
		return {16'($urandom), $urandom};
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic req_t make_req(input logic [2:0] kind, input logic [7:0] seg,
			input logic [47:0] owner, input logic [63:0] tag, input logic [63:0] data,
			input logic [3:0] count, input logic [31:0] now, input logic [30:0] age);
		req_t r;
		r.kind        = kind;
		r.segment     = seg;
		r.owner_id    = owner;
		r.name_tag    = tag;
		r.payload     = data;
		r.byte_count  = count;
		r.now_seconds = now;
		r.min_age     = age;
		return r;
	endfunction

	// Hold the beat until taken, then maybe drop start for a random stretch.
	task automatic issue(input req_t r);
		int gap;
		req   <= r;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		sent++;
		gap = 0;
		while (gap < 8 && $urandom_range(99) < idle_pct) gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic logic [3:0] entry_len();
		return ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(1, 8));
	endfunction

	// Claim a segment, mix all kinds, mostly under one owner, then drain and release.
	task automatic run_session();
		logic [7:0]  seg;
		logic [47:0] who;
		logic [63:0] tag;
		int          puts;
		int          pick;
		seg  = 8'($urandom_range(SEGMENTS - 1));
		who  = ($urandom_range(9) == 0) ? 48'd0 : rand48();
		tag  = rand64();
		puts = 0;
		issue(make_req(KIND_FREE, seg, rand48(), rand64(), '0, '0, wall, '0));
		issue(make_req(KIND_ALLOC, seg, who, tag, rand64(), '0, wall, '0));
		repeat ($urandom_range(1, 12)) begin
			pick = $urandom_range(99);
			wall += $urandom_range(3);
			if (pick < 45) begin
				issue(make_req(KIND_PUT, seg, who, tag, rand64(), entry_len(), wall, '0));
				puts++;
			end else if (pick < 80) begin
				issue(make_req(KIND_GET, seg, who, tag, rand64(), entry_len(),
					($urandom_range(9) == 0) ? $urandom : wall,
					($urandom_range(1) == 0) ? 31'd0 : 31'($urandom_range(1, 6))));
			end else if (pick < 88) begin
				issue(make_req(KIND_INFO, seg, who, tag, rand64(), '0, wall, '0));
			end else if (pick < 94) begin
				// wrong identity: tag off by one bit, owner sometimes off by one bit too
				issue(make_req((pick < 91) ? KIND_PUT : KIND_GET, seg,
					($urandom_range(1) == 0) ? who ^ (48'd1 << $urandom_range(47)) : who,
					tag ^ (64'd1 << $urandom_range(63)), rand64(), entry_len(), wall, '0));
			end else if (pick < 97) begin
				issue(make_req(KIND_ALLOC, seg, who, tag, rand64(), '0, wall, '0));
			end else begin
				issue(make_req(KIND_FREE, seg, who, tag, rand64(), '0, wall, '0));
			end
		end
		repeat (puts + 1) issue(make_req(KIND_GET, seg, who, tag, '0, '0, wall, '0));
		issue(make_req(KIND_INFO, seg, who, tag, '0, '0, wall, '0));
		issue(make_req(KIND_FREE, seg, who, tag, '0, '0, wall, '0));
	endtask

	// Run one segment past its capacity on both pointers.
	task automatic fill_and_drain();
		logic [7:0]  seg;
		logic [47:0] who;
		logic [63:0] tag;
		seg = 8'($urandom_range(SEGMENTS - 1));
		who = rand48();
		tag = rand64();
		issue(make_req(KIND_FREE, seg, who, tag, '0, '0, wall, '0));
		issue(make_req(KIND_ALLOC, seg, who, tag, '0, '0, wall, '0));
		repeat (CAPACITY + 1) begin
			wall += $urandom_range(2);
			issue(make_req(KIND_PUT, seg, who, tag, rand64(), entry_len(), wall, '0));
		end
		issue(make_req(KIND_INFO, seg, who, tag, '0, '0, wall, '0));
		repeat (CAPACITY + 1) issue(make_req(KIND_GET, seg, who, tag, '0, '0, wall, '0));
		issue(make_req(KIND_INFO, seg, who, tag, '0, '0, wall, '0));
		issue(make_req(KIND_FREE, seg, who, tag, '0, '0, wall, '0));
	endtask

	task automatic send_noise();
		logic [7:0] seg;
		seg = ($urandom_range(1) == 0) ? 8'($urandom_range(SEGMENTS - 1)) :
			8'($urandom_range(255));
		issue(make_req(3'($urandom_range(7)), seg,
			($urandom_range(4) == 0) ? 48'd0 : rand48(), rand64(), rand64(),
			4'($urandom_range(15)), $urandom,
			($urandom_range(2) == 0) ? 31'd0 : 31'($urandom)));
	endtask

	initial begin
		int          target;
		int          phase_pct [3];
		logic [47:0] top_id;
		logic [63:0] top_tag;
		logic [63:0] odd_tag;
		phase_pct = '{18, 51, 0};
		top_id    = '1;
		top_tag   = '1;
		odd_tag   = 64'h0123_4567_89AB_CDEF;
		arst_n    = 1'b0;
		start     = 1'b0;
		req       = '0;
		sent      = 0;
		idle_pct  = phase_pct[0];
		wall      = 32'd1000;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, every kind, odd lengths, aging across the signed boundary
		issue(make_req(KIND_ALLOC, 8'd0, top_id, top_tag, '0, '0, '0, '0));
		issue(make_req(KIND_ALLOC, 8'd0, 48'd1, 64'd1, '0, '0, '0, '0));
		issue(make_req(KIND_INFO, 8'd0, '0, '0, '0, '0, '0, '0));
		issue(make_req(KIND_PUT, 8'd0, top_id, top_tag, '1, 4'd8, 32'd0, '0));
		issue(make_req(KIND_PUT, 8'd0, top_id, top_tag, '1, 4'd0, 32'd100, '0));
		issue(make_req(KIND_PUT, 8'd0, top_id, top_tag, '1, 4'd15, 32'd100, '0));
		issue(make_req(KIND_PUT, 8'd0, top_id, top_tag, odd_tag, 4'd3, '1, '0));
		issue(make_req(KIND_PUT, 8'd0, top_id, top_tag ^ 64'd1, '1, 4'd8, '0, '0));
		issue(make_req(KIND_GET, 8'd0, top_id, top_tag, '0, '0, 32'd0, '1));
		issue(make_req(KIND_GET, 8'd0, top_id, top_tag, '0, '0, 32'd0, '0));
		issue(make_req(KIND_GET, 8'd0, top_id, top_tag, '0, '0, 32'd100, 31'd1));
		issue(make_req(KIND_GET, 8'd0, top_id, top_tag, '0, '0, 32'd101, 31'd1));
		issue(make_req(KIND_GET, 8'd0, top_id, top_tag, '0, '0, 32'd101, '0));
		issue(make_req(KIND_INFO, 8'd0, '0, '0, '0, '0, '0, '0));
		issue(make_req(KIND_FREE, 8'd0, '0, '0, '0, '0, '0, '0));
		issue(make_req(KIND_GET, 8'd0, top_id, top_tag, '0, '0, '1, '1));
		issue(make_req(KIND_GET, 8'd0, top_id, top_tag, '0, '0, '1, '0));
		issue(make_req(KIND_GET, 8'd0, top_id, top_tag, '0, '0, '1, '0));
		issue(make_req(KIND_FREE, 8'd0, '0, '0, '0, '0, '0, '0));
		issue(make_req(KIND_INFO, 8'd0, '0, '0, '0, '0, '0, '0));
		// a segment left free by an alloc with owner zero still serves that owner
		issue(make_req(KIND_ALLOC, 8'd15, '0, odd_tag, '0, '0, '0, '0));
		issue(make_req(KIND_PUT, 8'd15, '0, odd_tag, '1, 4'd5, 32'd7, '0));
		issue(make_req(KIND_GET, 8'd15, '0, odd_tag, '0, '0, 32'd7, '0));
		issue(make_req(KIND_ALLOC, 8'd16, top_id, top_tag, '0, '0, '0, '0));
		issue(make_req(KIND_INFO, 8'd255, '0, '0, '0, '0, '0, '0));
		issue(make_req(3'd5, 8'd0, top_id, top_tag, '0, '0, '0, '0));
		issue(make_req(3'd7, 8'd255, top_id, top_tag, '0, '0, '0, '0));
		issue(make_req(KIND_FREE, 8'd15, '0, '0, '0, '0, '0, '0));

		for (int p = 0; p < 3; p++) begin
			idle_pct = phase_pct[p];
			if (p == 0) fill_and_drain();
			target = sent + 380;
			while (sent < target) begin
				if ($urandom_range(9) < 7) run_session();
				else repeat ($urandom_range(1, 4)) send_noise();
			end
		end

		start <= 1'b0;
		while (awaiting != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (fails == 0 && awaiting == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// File: filelist.f
src/osq_pkg.sv
src/osq_ctrl.sv
src/osq_dp.sv
src/owned_segment_queue_store.sv
tb/osq_checker.sv
tb/tb_top.sv
